/* hdl/decimal_text_to_fixed_point_top_defines.svh */
// assertion macros used by the checker file
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH

// clocked property, switched off while reset is low
`define DTFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that also holds through reset
`define DTFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/dtfp_pkg.sv */
package dtfp_pkg;

    // fixed field widths
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;

    // defaults for the top level parameters
    localparam int INT_BITS_DEF        = 32;
    localparam int FRAC_BITS_DEF       = 32;
    localparam int MAX_FRAC_DIGITS_DEF = 9;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [VALUE_W-1:0] value_t;

    // parse phase
    typedef enum logic [1:0] {
        PH_BLANK,
        PH_BODY,
        PH_DONE
    } phase_t;

    // character codes
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_DOT   = 8'h2E;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;

    // floor(10^-k * 2^32) for k = 1..9
    localparam int TENTH_DEPTH = 9;
    localparam int TENTH_IDX_W = $clog2(TENTH_DEPTH);
    localparam logic [31:0] TENTH_POW_Q32 [TENTH_DEPTH] = '{
        32'd429496729, 32'd42949672, 32'd4294967, 32'd429496, 32'd42949,
        32'd4294, 32'd429, 32'd42, 32'd4
    };

endpackage

/* hdl/dtfp_if.sv */
// text character channel
interface dtfp_text_if;
    import dtfp_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  first;

    modport source (output valid, output character, output first, input ready);
    modport sink   (input valid, input character, input first, output ready);
endinterface

// parsed number channel
interface dtfp_result_if;
    import dtfp_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;
    logic   overflow;

    modport source (output valid, output value, output overflow, input ready);
    modport sink   (input valid, input value, input overflow, output ready);
endinterface

/* hdl/decimal_text_to_fixed_point_top.sv */
// channel | direction | payload               | handshake
// text    | in        | character[7:0], first | valid / ready
// result  | out       | value[63:0], overflow | valid / ready
//
// one character item per cycle sustained while the result register is free
// or its result is taken; an item goes through an input register and the
// parse state update, a terminating item then loads the result register
// reset clears the parse state and both valid registers, no warm-up pass
// input stalls only while its register is full and the result register holds
// an untaken result

module decimal_text_to_fixed_point_top #(
    parameter int INT_BITS        = dtfp_pkg::INT_BITS_DEF,
    parameter int FRAC_BITS       = dtfp_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    dtfp_text_if.sink     text,
    dtfp_result_if.source result
);
    import dtfp_pkg::*;

    localparam int IW = INT_BITS - 1;
    localparam int FW = FRAC_BITS;
    localparam int CW = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int NW = INT_BITS + 3;
    localparam logic [NW-1:0] MAX_INT = (NW'(1) << IW) - NW'(1);
    localparam logic [CW-1:0] MAX_FD  = CW'(MAX_FRAC_DIGITS);

    // input register
    logic   s1_valid_reg, s1_valid_next;
    char_t  s1_char_reg;
    logic   s1_first_reg;

    // parse state
    phase_t          phase_reg, phase_next;
    logic            negative_reg, negative_next;
    logic            in_fraction_reg, in_fraction_next;
    logic [IW-1:0]   integer_reg, integer_next;
    logic [FW-1:0]   fraction_reg, fraction_next;
    logic [CW-1:0]   frac_digits_reg, frac_digits_next;
    logic            saturated_reg, saturated_next;

    // result register
    logic   out_valid_reg, out_valid_next;
    value_t out_value_reg, out_value_next;
    logic   out_overflow_reg, out_overflow_next;

    logic advance;

    // state as seen by this item, after a new string clears it
    phase_t        cur_phase;
    logic          cur_neg, cur_inf, cur_sat;
    logic [IW-1:0] cur_int;
    logic [FW-1:0] cur_frac;
    logic [CW-1:0] cur_fd;

    logic       is_blank, is_sign, is_minus, is_dot, is_digit;
    logic       take_char, emit;
    logic [3:0] digit;

    logic [FW-1:0]   weight;
    logic [FW+3:0]   frac_add;
    logic [NW-1:0]   int_ext, int_sum;
    value_t          mag;

    // handshake
    assign advance       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign text.ready    = !s1_valid_reg || advance;
    assign s1_valid_next = text.valid ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    assign result.valid    = out_valid_reg;
    assign result.value    = out_value_reg;
    assign result.overflow = out_overflow_reg;

    // cleared view on a new string
    always_comb
    begin
        if (s1_first_reg)
        begin
            cur_phase = PH_BLANK;
            cur_neg   = 1'b0;
            cur_inf   = 1'b0;
            cur_sat   = 1'b0;
            cur_int   = '0;
            cur_frac  = '0;
            cur_fd    = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_neg   = negative_reg;
            cur_inf   = in_fraction_reg;
            cur_sat   = saturated_reg;
            cur_int   = integer_reg;
            cur_frac  = fraction_reg;
            cur_fd    = frac_digits_reg;
        end
    end

    // character classes
    assign is_blank = (s1_char_reg == CH_SPACE) || (s1_char_reg == CH_TAB);
    assign is_minus = (s1_char_reg == CH_MINUS);
    assign is_sign  = is_minus || (s1_char_reg == CH_PLUS);
    assign is_dot   = (s1_char_reg == CH_DOT);
    assign is_digit = (s1_char_reg >= CH_ZERO) && (s1_char_reg <= CH_NINE);
    assign digit    = s1_char_reg[3:0];

    // character belongs to the number body
    assign take_char = (cur_phase == PH_BODY) ||
                       ((cur_phase == PH_BLANK) && !is_blank && !is_sign);
    assign emit      = take_char && !is_dot && !is_digit;

    // phase transitions
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            unique case (cur_phase)
                PH_BLANK:
                begin
                    if (is_blank)
                        phase_next = PH_BLANK;
                    else if (emit)
                        phase_next = PH_DONE;
                    else
                        phase_next = PH_BODY;
                end
                PH_BODY:  phase_next = emit ? PH_DONE : PH_BODY;
                PH_DONE:  phase_next = PH_DONE;
                default:  phase_next = cur_phase;
            endcase
        end
    end

    // digit arithmetic
    assign weight   = FW'(TENTH_POW_Q32[TENTH_IDX_W'(cur_fd)] >> (32 - FW));
    assign frac_add = weight * digit;
    assign int_ext  = NW'(cur_int);
    assign int_sum  = (int_ext << 3) + (int_ext << 1) + NW'(digit);

    // parse state update
    always_comb
    begin
        negative_next    = negative_reg;
        in_fraction_next = in_fraction_reg;
        integer_next     = integer_reg;
        fraction_next    = fraction_reg;
        frac_digits_next = frac_digits_reg;
        saturated_next   = saturated_reg;
        if (advance)
        begin
            negative_next    = cur_neg || ((cur_phase == PH_BLANK) && is_minus);
            in_fraction_next = cur_inf || (take_char && is_dot);
            integer_next     = cur_int;
            fraction_next    = cur_frac;
            frac_digits_next = cur_fd;
            saturated_next   = cur_sat;
            if (take_char && is_digit)
            begin
                if (cur_inf)
                begin
                    if (cur_fd < MAX_FD)
                    begin
                        fraction_next    = cur_frac + frac_add[FW-1:0];
                        frac_digits_next = cur_fd + CW'(1);
                    end
                end
                else if (cur_sat || (int_sum > MAX_INT))
                begin
                    integer_next   = MAX_INT[IW-1:0];
                    saturated_next = 1'b1;
                end
                else
                begin
                    integer_next = int_sum[IW-1:0];
                end
            end
        end
    end

    // result assembly
    always_comb
    begin
        mag = (VALUE_W'(cur_int) << FW) | VALUE_W'(cur_sat ? {FW{1'b1}} : cur_frac);
        out_value_next    = out_value_reg;
        out_overflow_next = out_overflow_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        if (advance && emit)
        begin
            out_valid_next    = 1'b1;
            out_value_next    = cur_neg ? (VALUE_W'(0) - mag) : mag;
            out_overflow_next = cur_sat;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_BLANK;
            negative_reg    <= 1'b0;
            in_fraction_reg <= 1'b0;
            integer_reg     <= '0;
            fraction_reg    <= '0;
            frac_digits_reg <= '0;
            saturated_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            phase_reg       <= phase_next;
            negative_reg    <= negative_next;
            in_fraction_reg <= in_fraction_next;
            integer_reg     <= integer_next;
            fraction_reg    <= fraction_next;
            frac_digits_reg <= frac_digits_next;
            saturated_reg   <= saturated_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_char_reg  <= text.character;
            s1_first_reg <= text.first;
        end
        out_value_reg    <= out_value_next;
        out_overflow_reg <= out_overflow_next;
    end

endmodule

/* hdl/dtfp_checker.sv */
module dtfp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input dtfp_pkg::value_t out_value
);
    import dtfp_pkg::*;

`include "decimal_text_to_fixed_point_top_defines.svh"

    // input side never waits on an empty result register
    `DTFP_ASSERT_ALWAYS(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with no result pending")

    // a result appearing after an idle output comes from a terminating item that passed through the input register
    `DTFP_ASSERT(a_result_has_item, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a terminating item")

    // a stalled result holds its value
    `DTFP_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(out_value), "stalled result changed")

endmodule

bind decimal_text_to_fixed_point_top dtfp_checker u_dtfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text.valid),
    .in_ready  (text.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.value)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import dtfp_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS   = 1500;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 5000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RUN_LIMIT_NS   = 10_000_000;

    // parser limits at the default parameters
    localparam int          KEPT_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF;
    localparam logic [63:0] INT_LIMIT        = (64'd1 << (INT_BITS_DEF - 1)) - 64'd1;
    localparam char_t       NUL_CHAR         = 8'h00;

    typedef struct packed {
        value_t val;
        logic   ovf;
    } parsed_t;

    typedef struct {
        string  txt;
        char_t  term;
        bit     known;
        value_t val;
        bit     ovf;
    } text_row_t;

    logic clk;
    logic rst_n;

    dtfp_text_if   text_ch ();
    dtfp_result_if result_ch ();

    decimal_text_to_fixed_point_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    // parser state mirror
    phase_t      ph;
    bit          neg;
    bit          in_frac;
    logic [31:0] int_mag;
    logic [31:0] frac_mag;
    int          frac_cnt;
    bit          sat;

    parsed_t expected_results [$];

    int  mismatches;
    int  results_checked;
    int  chars_sent;
    int  strings_sent;
    bit  fresh;
    bit  typed_on;
    parsed_t typed_result;
    bit  send_idle;
    bit  recv_stall;
    bit  hold_results;

    // directed strings, typed results only where obvious
    text_row_t directed_rows [22] = '{
        '{"0",                     NUL_CHAR, 1, 64'h0000_0000_0000_0000, 0},
        '{"",                      NUL_CHAR, 1, 64'h0000_0000_0000_0000, 0},
        '{"-",                     NUL_CHAR, 1, 64'h0000_0000_0000_0000, 0},
        '{"  \t+7",                ";",      1, 64'h0000_0007_0000_0000, 0},
        '{"-0.0",                  NUL_CHAR, 1, 64'h0000_0000_0000_0000, 0},
        '{"2147483647",            NUL_CHAR, 1, 64'h7FFF_FFFF_0000_0000, 0},
        '{"2147483648",            NUL_CHAR, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1},
        '{"-99999999999.5",        NUL_CHAR, 1, 64'h8000_0000_0000_0001, 1},
        '{"0.999999999999",        NUL_CHAR, 0, 64'h0, 0},
        '{"3.1.4",                 NUL_CHAR, 0, 64'h0, 0},
        '{"1",                     "-",      1, 64'h0000_0001_0000_0000, 0},
        '{"+",                     "-",      1, 64'h0000_0000_0000_0000, 0},
        '{"12x99",                 "5",      1, 64'h0000_000C_0000_0000, 0},
        '{"987",                   "6",      0, 64'h0, 0},
        '{" \t.5",                 NUL_CHAR, 0, 64'h0, 0},
        '{".",                     NUL_CHAR, 1, 64'h0000_0000_0000_0000, 0},
        '{"",                      8'hFF,    1, 64'h0000_0000_0000_0000, 0},
        '{"4",                     8'h80,    1, 64'h0000_0004_0000_0000, 0},
        '{"9",                     ":",      1, 64'h0000_0009_0000_0000, 0},
        '{"-1",                    "/",      1, 64'hFFFF_FFFF_0000_0000, 0},
        '{"-2147483647.999999999", NUL_CHAR, 0, 64'h0, 0},
        '{"0.000000001",           " ",      0, 64'h0, 0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d results still pending", expected_results.size());
        $display("testbench failed");
        $finish;
    end

    function automatic void clear_parse();
        ph       = PH_BLANK;
        neg      = 1'b0;
        in_frac  = 1'b0;
        int_mag  = '0;
        frac_mag = '0;
        frac_cnt = 0;
        sat      = 1'b0;
    endfunction

    // one character into the parser mirror, returns 1 when a number ends
    function automatic bit parse_char(input char_t c, input bit start,
                                      output value_t val, output logic ovf);
        logic [63:0] grown;
        logic [63:0] scale;
        logic [63:0] mag;
        val = '0;
        ovf = 1'b0;
        if (start)
            clear_parse();
        if (ph == PH_DONE)
            return 1'b0;
        if (ph == PH_BLANK)
        begin
            if (c == CH_SPACE || c == CH_TAB)
                return 1'b0;
            ph = PH_BODY;
            if (c == CH_MINUS)
            begin
                neg = 1'b1;
                return 1'b0;
            end
            if (c == CH_PLUS)
                return 1'b0;
        end
        if (c == CH_DOT)
        begin
            in_frac = 1'b1;
            return 1'b0;
        end
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (in_frac)
            begin
                // digit k weighs floor(2^32 / 10^k), extra digits dropped
                if (frac_cnt < KEPT_FRAC_DIGITS)
                begin
                    scale = 64'd10;
                    for (int k = 0; k < frac_cnt; k++)
                        scale = scale * 64'd10;
                    grown    = 64'h1_0000_0000 / scale;
                    frac_mag = frac_mag + 32'(c - CH_ZERO) * grown[31:0];
                    frac_cnt++;
                end
            end
            else
            begin
                // integer part saturates at the largest magnitude
                grown = 64'(int_mag) * 64'd10 + 64'(c - CH_ZERO);
                if (sat || grown > INT_LIMIT)
                begin
                    int_mag = INT_LIMIT[31:0];
                    sat     = 1'b1;
                end
                else
                    int_mag = grown[31:0];
            end
            return 1'b0;
        end
        // any other byte ends the number
        mag = sat ? {int_mag, 32'hFFFF_FFFF} : {int_mag, frac_mag};
        val = neg ? -mag : mag;
        ovf = sat;
        ph  = PH_DONE;
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one character, predict on acceptance
    task automatic send_char(input char_t c, input bit start);
        int      gap;
        value_t  val;
        logic    ovf;
        gap = send_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.character <= c;
        text_ch.first     <= start;
        do
            @(posedge clk);
        while (!text_ch.ready);
        chars_sent++;
        if (parse_char(c, start, val, ovf))
        begin
            if (typed_on)
            begin
                expected_results.push_back(typed_result);
                typed_on = 1'b0;
            end
            else
                expected_results.push_back('{val: val, ovf: ovf});
        end
    endtask

    // next character of the current string, first flag on its opening byte
    task automatic send_next(input char_t c);
        send_char(c, fresh);
        fresh = 1'b0;
    endtask

    // mostly well-formed numbers with random content, some noise and broken strings
    task automatic send_random_string();
        int    kind;
        int    n;
        int    r;
        char_t c;
        kind  = $urandom_range(0, 99);
        fresh = 1'b1;
        strings_sent++;
        if (kind < 8)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_next(char_t'($urandom_range(0, 255)));
            return;
        end
        // leading blanks
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n) send_next(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
        // optional sign
        r = $urandom_range(0, 3);
        if (r == 0)
            send_next(CH_MINUS);
        else if (r == 1)
            send_next(CH_PLUS);
        // integer digits, a few long enough to saturate
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
        repeat (n) send_next(CH_ZERO + char_t'($urandom_range(0, 9)));
        // fraction with an occasional stray dot
        if ($urandom_range(0, 2) != 0)
        begin
            send_next(CH_DOT);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_next(CH_DOT);
                send_next(CH_ZERO + char_t'($urandom_range(0, 9)));
            end
        end
        // broken string, dropped by the next first flag
        if (kind < 14)
            return;
        // terminator
        if ($urandom_range(0, 2) == 0)
            c = NUL_CHAR;
        else
        begin
            do
                c = char_t'($urandom_range(0, 255));
            while (c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE));
        end
        send_next(c);
        // bytes after the end are ignored
        repeat ($urandom_range(0, 2)) send_next(char_t'($urandom_range(0, 255)));
    endtask

    // result receiver with random stalls and one long hold-off
    initial
    begin : receiver
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else
            begin
                gap = recv_stall ? gap_len() : 0;
                result_ch.ready <= (gap == 0);
                if (gap > 1)
                    repeat (gap - 1) @(posedge clk);
            end
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        parsed_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: value %h overflow %b",
                       result_ch.value, result_ch.overflow);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (result_ch.value !== want.val)
                begin
                    $error("value: expected %h, actual %h", want.val, result_ch.value);
                    mismatches++;
                end
                if (result_ch.overflow !== want.ovf)
                begin
                    $error("overflow: expected %b, actual %b", want.ovf, result_ch.overflow);
                    mismatches++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        int rows_done;
        int chars_base;
        int waited;
        rst_n             <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.character <= NUL_CHAR;
        text_ch.first     <= 1'b0;
        mismatches      = 0;
        results_checked = 0;
        chars_sent      = 0;
        strings_sent    = 0;
        typed_on        = 1'b0;
        hold_results    = 1'b0;
        send_idle       = 1'b1;
        recv_stall      = 1'b1;
        rows_done       = 0;
        clear_parse();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings
        foreach (directed_rows[i])
        begin
            fresh        = 1'b1;
            typed_on     = directed_rows[i].known;
            typed_result = '{val: directed_rows[i].val, ovf: directed_rows[i].ovf};
            strings_sent++;
            for (int j = 0; j < directed_rows[i].txt.len(); j++)
                send_next(directed_rows[i].txt[j]);
            send_next(directed_rows[i].term);
            typed_on = 1'b0;
        end

        // random strings, idling changes every 40 strings
        chars_base = chars_sent;
        while (chars_sent - chars_base < RANDOM_ITEMS)
        begin
            if (rows_done % 40 == 0)
            begin
                if ((rows_done / 40) % 4 == 3)
                begin
                    send_idle  = 1'b0;
                    recv_stall = 1'b0;
                end
                else
                begin
                    send_idle  = ($urandom_range(0, 3) != 0);
                    recv_stall = ($urandom_range(0, 3) != 0);
                end
            end
            // back-to-back items against a held-off receiver
            if (rows_done == 60)
            begin
                send_idle    = 1'b0;
                hold_results = 1'b1;
            end
            send_random_string();
            rows_done++;
        end
        text_ch.valid <= 1'b0;

        // drain
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches += expected_results.size();
        end

        $display("parsed %0d strings from %0d characters, %0d numbers compared",
                 strings_sent, chars_sent, results_checked);
        $display("with idle and back-to-back stretches and a %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/dtfp_pkg.sv
hdl/dtfp_if.sv
hdl/decimal_text_to_fixed_point_top.sv
hdl/dtfp_checker.sv
dv/testbench.sv
